// ----- src/oblivious_distribute_engine_assert.svh -----
// Assertion macros, sampled on clk and held off while rst_n is low.
`ifndef OBLIVIOUS_DISTRIBUTE_ENGINE_ASSERT_SVH
`define OBLIVIOUS_DISTRIBUTE_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define ODE_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ODE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/odist_pkg.sv -----
`timescale 1ns / 1ps

package odist_pkg;

    localparam int DEST_W         = 9;
    localparam int ROUTE_W        = DEST_W + 1;
    localparam int OUT_DEST_W     = 10;
    localparam int COUNT_W        = 10;
    localparam int PAYLOAD_PORT_W = 64;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RUN
    } top_state_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_ANY,
        SQ_CNT,
        SQ_DEC,
        SQ_PUSH,
        SQ_SWRD,
        SQ_SWA,
        SQ_SWB,
        SQ_POP,
        SQ_P2
    } seq_state_t;

endpackage

// ----- src/oblivious_distribute_engine.sv -----
`timescale 1ns / 1ps
// Channel | Handshake           | Beat carries
// --------+---------------------+-------------------------------------------------------
// in      | in_valid / in_ready | operation, dest_index, is_padding, payload, last_entry,
//         |                     | read_slot
// out     | out_valid/out_ready | status, out_dest_index, out_padding, out_payload,
//         |                     | entry_count
// A load is answered from the output register; a read also passes the registered store read.
// The last load runs the network: per level each counted entry is read once, and each
// compared pair is read, then written back in two steps through the single write port of the store.
// in_ready is low while a read or the network is in progress, or while a result is stalled.
// Reset clears the count and the closed flag; the store itself is not cleared.

`include "oblivious_distribute_engine_assert.svh"

module oblivious_distribute_engine #(
    parameter int MAX_ENTRIES   = 512,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 operation,
    input  logic [odist_pkg::DEST_W-1:0]         dest_index,
    input  logic                                 is_padding,
    input  logic [odist_pkg::PAYLOAD_PORT_W-1:0] payload,
    input  logic                                 last_entry,
    input  logic [odist_pkg::DEST_W-1:0]         read_slot,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           status,
    output logic [odist_pkg::OUT_DEST_W-1:0]     out_dest_index,
    output logic                                 out_padding,
    output logic [odist_pkg::PAYLOAD_PORT_W-1:0] out_payload,
    output logic [odist_pkg::COUNT_W-1:0]        entry_count
);

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int DW  = odist_pkg::DEST_W;
    localparam int XW  = (CW > DW) ? CW : DW;
    localparam int EW  = PAYLOAD_WIDTH + odist_pkg::ROUTE_W;
    localparam int OW  = (CW > odist_pkg::COUNT_W) ? CW : odist_pkg::COUNT_W;
    localparam int ODW = odist_pkg::OUT_DEST_W;

    odist_pkg::top_state_t state_reg, state_next;

    logic [CW-1:0]                      count_reg, count_next;
    logic                               closed_reg, closed_next;
    logic                               out_valid_reg, out_valid_next;
    odist_pkg::status_t                 status_reg, status_next;
    logic [ODW-1:0]                     odest_reg, odest_next;
    logic                               opad_reg, opad_next;
    logic [odist_pkg::PAYLOAD_PORT_W-1:0] opay_reg, opay_next;
    logic [odist_pkg::COUNT_W-1:0]      ocnt_reg, ocnt_next;

    logic           accept, is_read, full, in_range;
    logic [CW-1:0]  base_cnt, new_cnt;
    logic [OW-1:0]  new_cnt_x, cnt_x;
    logic [XW-1:0]  slot_x;

    logic [AW-1:0]  mem_rd_a_addr, mem_wr_addr;
    logic [EW-1:0]  mem_rd_a_data, mem_rd_b_data, mem_wr_data;
    logic           mem_wr_en;

    logic           seq_start, seq_done, seq_wr_en;
    logic [AW-1:0]  seq_rd_a_addr, seq_rd_b_addr, seq_wr_addr;
    logic [EW-1:0]  seq_wr_data;

    logic           rd_pad;
    logic [DW-1:0]  rd_dest;

    always_comb
    begin
        in_ready  = (state_reg == odist_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
        accept    = in_valid && in_ready;
        is_read   = (odist_pkg::op_t'(operation) == odist_pkg::OP_READ);
        base_cnt  = closed_reg ? '0 : count_reg;
        full      = base_cnt >= CW'(MAX_ENTRIES);
        new_cnt   = full ? base_cnt : (base_cnt + CW'(1));
        new_cnt_x = OW'(new_cnt);
        cnt_x     = OW'(count_reg);
        slot_x    = XW'(read_slot);
        in_range  = slot_x < XW'(count_reg);
        seq_start = accept && !is_read && last_entry;
        rd_pad    = mem_rd_a_data[EW-1];
        rd_dest   = mem_rd_a_data[EW-2 -: DW];
    end

    always_comb
    begin
        if (state_reg == odist_pkg::ST_RUN)
        begin
            mem_rd_a_addr = seq_rd_a_addr;
            mem_wr_en     = seq_wr_en;
            mem_wr_addr   = seq_wr_addr;
            mem_wr_data   = seq_wr_data;
        end
        else
        begin
            mem_rd_a_addr = slot_x[AW-1:0];
            mem_wr_en     = accept && !is_read && !full;
            mem_wr_addr   = base_cnt[AW-1:0];
            mem_wr_data   = {is_padding, dest_index, payload[PAYLOAD_WIDTH-1:0]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            odist_pkg::ST_IDLE:
            begin
                if (accept && is_read && in_range)
                begin
                    state_next = odist_pkg::ST_READ;
                end
                else if (seq_start)
                begin
                    state_next = odist_pkg::ST_RUN;
                end
            end
            odist_pkg::ST_READ: state_next = odist_pkg::ST_IDLE;
            odist_pkg::ST_RUN:
            begin
                if (seq_done)
                begin
                    state_next = odist_pkg::ST_IDLE;
                end
            end
            default: state_next = odist_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        closed_next    = closed_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        odest_next     = odest_reg;
        opad_next      = opad_reg;
        opay_next      = opay_reg;
        ocnt_next      = ocnt_reg;
        case (state_reg)
            odist_pkg::ST_IDLE:
            begin
                if (accept && !is_read)
                begin
                    count_next     = new_cnt;
                    closed_next    = last_entry;
                    out_valid_next = 1'b1;
                    status_next    = full ? odist_pkg::STATUS_FULL : odist_pkg::STATUS_OK;
                    odest_next     = '0;
                    opad_next      = 1'b0;
                    opay_next      = '0;
                    ocnt_next      = new_cnt_x[odist_pkg::COUNT_W-1:0];
                end
                else if (accept && !in_range)
                begin
                    out_valid_next = 1'b1;
                    status_next    = odist_pkg::STATUS_RANGE;
                    odest_next     = '0;
                    opad_next      = 1'b0;
                    opay_next      = '0;
                    ocnt_next      = cnt_x[odist_pkg::COUNT_W-1:0];
                end
            end
            odist_pkg::ST_READ:
            begin
                out_valid_next = 1'b1;
                status_next    = odist_pkg::STATUS_OK;
                // once closed, padding entries sit at the count
                odest_next     = (closed_reg && rd_pad) ? cnt_x[ODW-1:0] : ODW'(rd_dest);
                opad_next      = rd_pad;
                opay_next      = odist_pkg::PAYLOAD_PORT_W'(mem_rd_a_data[PAYLOAD_WIDTH-1:0]);
                ocnt_next      = cnt_x[odist_pkg::COUNT_W-1:0];
            end
            default:
            begin
                closed_next = closed_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= odist_pkg::ST_IDLE;
            count_reg     <= '0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            closed_reg    <= closed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        odest_reg  <= odest_next;
        opad_reg   <= opad_next;
        opay_reg   <= opay_next;
        ocnt_reg   <= ocnt_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign out_dest_index = odest_reg;
    assign out_padding    = opad_reg;
    assign out_payload    = opay_reg;
    assign entry_count    = ocnt_reg;

    odist_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW),
        .EW    (EW)
    ) u_mem (
        .clk       (clk),
        .rd_a_addr (mem_rd_a_addr),
        .rd_b_addr (seq_rd_b_addr),
        .rd_a_data (mem_rd_a_data),
        .rd_b_data (mem_rd_b_data),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data)
    );

    odist_seq #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (seq_start),
        .total     (new_cnt),
        .rd_a_data (mem_rd_a_data),
        .rd_b_data (mem_rd_b_data),
        .done      (seq_done),
        .rd_a_addr (seq_rd_a_addr),
        .rd_b_addr (seq_rd_b_addr),
        .wr_en     (seq_wr_en),
        .wr_addr   (seq_wr_addr),
        .wr_data   (seq_wr_data)
    );

    `ODE_ASSERT_IMPLY(a_busy_blocks_input, state_reg != odist_pkg::ST_IDLE, !in_ready, "busy")
    `ODE_ASSERT_IMPLY(a_count_cap, 1'b1, count_reg <= CW'(MAX_ENTRIES), "count beyond capacity")
    `ODE_ASSERT_IMPLY(a_done_in_run, seq_done, state_reg == odist_pkg::ST_RUN, "done outside run")
    `ODE_ASSERT_NEXT(a_read_gives_beat, state_reg == odist_pkg::ST_READ, out_valid, "read lost")

endmodule

// ----- src/odist_mem.sv -----
`timescale 1ns / 1ps

module odist_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int EW    = 74
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_a_addr,
    input  logic [AW-1:0] rd_b_addr,
    output logic [EW-1:0] rd_a_data,
    output logic [EW-1:0] rd_b_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [EW-1:0] wr_data
);

    logic [EW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

// ----- src/odist_seq.sv -----
`timescale 1ns / 1ps

module odist_seq #(
    parameter int MAX_ENTRIES   = 512,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]             total,
    input  logic [PAYLOAD_WIDTH+odist_pkg::ROUTE_W-1:0]  rd_a_data,
    input  logic [PAYLOAD_WIDTH+odist_pkg::ROUTE_W-1:0]  rd_b_data,
    output logic                                         done,
    output logic [$clog2(MAX_ENTRIES)-1:0]               rd_a_addr,
    output logic [$clog2(MAX_ENTRIES)-1:0]               rd_b_addr,
    output logic                                         wr_en,
    output logic [$clog2(MAX_ENTRIES)-1:0]               wr_addr,
    output logic [PAYLOAD_WIDTH+odist_pkg::ROUTE_W-1:0]  wr_data
);

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int DW  = odist_pkg::DEST_W;
    localparam int XW  = (CW > DW) ? CW : DW;
    localparam int EW  = PAYLOAD_WIDTH + odist_pkg::ROUTE_W;
    localparam int LW  = $clog2(AW + 1);
    localparam int SD  = AW + 2;
    localparam int SIW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    odist_pkg::seq_state_t state_reg, state_next;

    logic [SPW-1:0] sp_reg, sp_next;
    logic           pend_reg, pend_next;
    logic [CW-1:0]  any_n_reg, any_n_next;
    logic [CW-1:0]  total_reg, total_next;
    logic [CW-1:0]  p_reg, p_next;
    logic [LW-1:0]  kp_reg, kp_next;
    logic [CW-1:0]  t_start_reg, t_start_next;
    logic [CW-1:0]  t_off_reg, t_off_next;
    logic [LW-1:0]  t_k_reg, t_k_next;
    logic [CW-1:0]  a0_reg, a0_next;
    logic [CW-1:0]  dist_reg, dist_next;
    logic [CW-1:0]  len_reg, len_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  lim_reg, lim_next;
    logic [CW-1:0]  thr_reg, thr_next;
    logic [CW-1:0]  m_reg, m_next;
    logic           xr_reg, xr_next;
    logic           any2_reg, any2_next;
    logic           phase_reg, phase_next;
    logic           cond_reg, cond_next;
    logic [EW-1:0]  hold_reg, hold_next;

    logic [CW-1:0] st_start_mem [SD];
    logic [CW-1:0] st_off_mem [SD];
    logic [LW-1:0] st_k_mem [SD];

    logic           push_en;
    logic [CW-1:0]  push_start;
    logic [CW-1:0]  push_off;
    logic [LW-1:0]  push_k;
    logic [SPW-1:0] sp_dec;

    logic [CW-1:0] nm1, p_any, q_any, q_dec, off_any;
    logic [LW-1:0] kp_any;
    logic [CW-1:0] n_pow, half, hmask, ohalf, ii;
    logic [CW:0]   sum_om;
    logic          c3;
    logic [CW-1:0] sum_a, sum_b;
    logic          pad_a, pad_b;
    logic [DW-1:0] dest_a, dest_b;
    logic [XW-1:0] eff_a;
    logic          below, sw_two, cond_now;

    // highest power of two strictly below the block size
    always_comb
    begin
        nm1    = any_n_reg - CW'(1);
        p_any  = '0;
        kp_any = '0;
        for (int j = 0; j < CW; j++)
        begin
            if (nm1[j])
            begin
                p_any  = CW'(1) << j;
                kp_any = LW'(j);
            end
        end
        q_any = any_n_reg - p_any;
    end

    always_comb
    begin
        q_dec   = any_n_reg - p_reg;
        off_any = (p_reg - q_dec + m_reg) & (p_reg - CW'(1));
        n_pow   = CW'(1) << t_k_reg;
        half    = n_pow >> 1;
        hmask   = half - CW'(1);
        ohalf   = t_off_reg & hmask;
        sum_om  = (CW+1)'(t_off_reg) + (CW+1)'(m_reg);
        c3      = (t_off_reg < half) ^ (((CW+1)'(ohalf) + (CW+1)'(m_reg)) < (CW+1)'(half));
        ii      = CW'(sum_om) & hmask;
        sum_a   = a0_reg + idx_reg;
        sum_b   = sum_a + dist_reg;
        pad_a   = rd_a_data[EW-1];
        pad_b   = rd_b_data[EW-1];
        dest_a  = rd_a_data[EW-2 -: DW];
        dest_b  = rd_b_data[EW-2 -: DW];
        // padding entries are bound to the slot just past the batch
        eff_a    = pad_a ? XW'(total_reg) : XW'(dest_a);
        below    = eff_a < XW'(lim_reg);
        sw_two   = (!pad_a && (dest_a != '0)) || (!pad_b && (dest_b == '0));
        cond_now = any2_reg ? sw_two : (xr_reg ^ (thr_reg <= idx_reg));
        sp_dec   = sp_reg - SPW'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            odist_pkg::SQ_IDLE:
            begin
                if (start)
                begin
                    state_next = odist_pkg::SQ_ANY;
                end
            end
            odist_pkg::SQ_ANY:
            begin
                if (any_n_reg <= CW'(1))
                begin
                    state_next = odist_pkg::SQ_IDLE;
                end
                else if (any_n_reg == CW'(2))
                begin
                    state_next = odist_pkg::SQ_SWRD;
                end
                else
                begin
                    state_next = odist_pkg::SQ_CNT;
                end
            end
            odist_pkg::SQ_CNT:
            begin
                if ((idx_reg >= len_reg) && !pend_reg)
                begin
                    state_next = odist_pkg::SQ_DEC;
                end
            end
            odist_pkg::SQ_DEC:
            begin
                if (phase_reg && (t_k_reg != LW'(1)))
                begin
                    state_next = odist_pkg::SQ_PUSH;
                end
                else
                begin
                    state_next = odist_pkg::SQ_SWRD;
                end
            end
            odist_pkg::SQ_PUSH: state_next = odist_pkg::SQ_SWRD;
            odist_pkg::SQ_SWRD: state_next = odist_pkg::SQ_SWA;
            odist_pkg::SQ_SWA:  state_next = odist_pkg::SQ_SWB;
            odist_pkg::SQ_SWB:
            begin
                if ((idx_reg + CW'(1)) == len_reg)
                begin
                    state_next = odist_pkg::SQ_POP;
                end
                else
                begin
                    state_next = odist_pkg::SQ_SWRD;
                end
            end
            odist_pkg::SQ_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = odist_pkg::SQ_ANY;
                end
                else
                begin
                    state_next = odist_pkg::SQ_P2;
                end
            end
            odist_pkg::SQ_P2:
            begin
                if (t_k_reg == '0)
                begin
                    state_next = odist_pkg::SQ_POP;
                end
                else
                begin
                    state_next = odist_pkg::SQ_CNT;
                end
            end
            default: state_next = odist_pkg::SQ_IDLE;
        endcase
    end

    always_comb
    begin
        sp_next      = sp_reg;
        pend_next    = pend_reg;
        any_n_next   = any_n_reg;
        total_next   = total_reg;
        p_next       = p_reg;
        kp_next      = kp_reg;
        t_start_next = t_start_reg;
        t_off_next   = t_off_reg;
        t_k_next     = t_k_reg;
        a0_next      = a0_reg;
        dist_next    = dist_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        lim_next     = lim_reg;
        thr_next     = thr_reg;
        m_next       = m_reg;
        xr_next      = xr_reg;
        any2_next    = any2_reg;
        phase_next   = phase_reg;
        cond_next    = cond_reg;
        hold_next    = hold_reg;
        push_en      = 1'b0;
        push_start   = '0;
        push_off     = '0;
        push_k       = '0;
        done         = 1'b0;
        rd_a_addr    = '0;
        rd_b_addr    = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        case (state_reg)
            odist_pkg::SQ_IDLE:
            begin
                if (start)
                begin
                    any_n_next = total;
                    total_next = total;
                    sp_next    = '0;
                end
            end
            odist_pkg::SQ_ANY:
            begin
                idx_next  = '0;
                a0_next   = '0;
                any2_next = 1'b0;
                if (any_n_reg <= CW'(1))
                begin
                    done = 1'b1;
                end
                else if (any_n_reg == CW'(2))
                begin
                    dist_next  = CW'(1);
                    len_next   = CW'(1);
                    any2_next  = 1'b1;
                    any_n_next = CW'(1);
                end
                else
                begin
                    p_next     = p_any;
                    kp_next    = kp_any;
                    len_next   = q_any;
                    lim_next   = q_any;
                    m_next     = '0;
                    phase_next = 1'b0;
                    pend_next  = 1'b0;
                end
            end
            odist_pkg::SQ_CNT:
            begin
                if (idx_reg < len_reg)
                begin
                    rd_a_addr = sum_a[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && below)
                begin
                    m_next = m_reg + CW'(1);
                end
            end
            odist_pkg::SQ_DEC:
            begin
                idx_next  = '0;
                any2_next = 1'b0;
                if (!phase_reg)
                begin
                    push_en    = 1'b1;
                    push_start = q_dec;
                    push_off   = off_any;
                    push_k     = kp_reg;
                    a0_next    = '0;
                    dist_next  = p_reg;
                    len_next   = q_dec;
                    xr_next    = 1'b0;
                    thr_next   = m_reg;
                    any_n_next = q_dec;
                end
                else if (t_k_reg == LW'(1))
                begin
                    a0_next   = t_start_reg;
                    dist_next = CW'(1);
                    len_next  = CW'(1);
                    xr_next   = (m_reg == t_off_reg);
                    thr_next  = '1;
                end
                else
                begin
                    push_en    = 1'b1;
                    push_start = t_start_reg + half;
                    push_off   = ii;
                    push_k     = t_k_reg - LW'(1);
                    a0_next    = t_start_reg;
                    dist_next  = half;
                    len_next   = half;
                    xr_next    = c3;
                    thr_next   = ii;
                end
            end
            odist_pkg::SQ_PUSH:
            begin
                push_en    = 1'b1;
                push_start = t_start_reg;
                push_off   = ohalf;
                push_k     = t_k_reg - LW'(1);
            end
            odist_pkg::SQ_SWRD:
            begin
                rd_a_addr = sum_a[AW-1:0];
                rd_b_addr = sum_b[AW-1:0];
            end
            odist_pkg::SQ_SWA:
            begin
                cond_next = cond_now;
                hold_next = rd_a_data;
                wr_en     = cond_now;
                wr_addr   = sum_a[AW-1:0];
                wr_data   = rd_b_data;
            end
            odist_pkg::SQ_SWB:
            begin
                wr_en    = cond_reg;
                wr_addr  = sum_b[AW-1:0];
                wr_data  = hold_reg;
                idx_next = idx_reg + CW'(1);
            end
            odist_pkg::SQ_POP:
            begin
                if (sp_reg != '0)
                begin
                    t_start_next = st_start_mem[sp_dec[SIW-1:0]];
                    t_off_next   = st_off_mem[sp_dec[SIW-1:0]];
                    t_k_next     = st_k_mem[sp_dec[SIW-1:0]];
                    sp_next      = sp_dec;
                end
            end
            odist_pkg::SQ_P2:
            begin
                a0_next    = t_start_reg;
                len_next   = n_pow;
                lim_next   = t_start_reg + half;
                idx_next   = '0;
                m_next     = '0;
                phase_next = 1'b1;
                pend_next  = 1'b0;
                any2_next  = 1'b0;
            end
            default:
            begin
                sp_next = sp_reg;
            end
        endcase
        if (push_en)
        begin
            sp_next = sp_reg + SPW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= odist_pkg::SQ_IDLE;
            sp_reg    <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        any_n_reg   <= any_n_next;
        total_reg   <= total_next;
        p_reg       <= p_next;
        kp_reg      <= kp_next;
        t_start_reg <= t_start_next;
        t_off_reg   <= t_off_next;
        t_k_reg     <= t_k_next;
        a0_reg      <= a0_next;
        dist_reg    <= dist_next;
        len_reg     <= len_next;
        idx_reg     <= idx_next;
        lim_reg     <= lim_next;
        thr_reg     <= thr_next;
        m_reg       <= m_next;
        xr_reg      <= xr_next;
        any2_reg    <= any2_next;
        phase_reg   <= phase_next;
        cond_reg    <= cond_next;
        hold_reg    <= hold_next;
        if (push_en)
        begin
            st_start_mem[sp_reg[SIW-1:0]] <= push_start;
            st_off_mem[sp_reg[SIW-1:0]]   <= push_off;
            st_k_mem[sp_reg[SIW-1:0]]     <= push_k;
        end
    end

endmodule
